FILE: sv/bvh_ray_traversal_assert.svh
// Assertion macros used by the checker file of the tree walker.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef BVH_RAY_TRAVERSAL_ASSERT_SVH
`define BVH_RAY_TRAVERSAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVH_RT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVH_RT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bvh_rt_pkg.sv
// ----------------------------------------------------------------------------
// bvh_rt_pkg
// Shared constants, command codes and word layouts of the tree walker.
// ----------------------------------------------------------------------------
package bvh_rt_pkg;

    // Default sizes of the tree, the stack and the coordinates.
    localparam int DEF_NODE_COUNT  = 128;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_COORD_WIDTH = 32;

    // Results one ray may give before the walk is aborted.
    localparam int MAX_RESULTS = 64;

    // Fraction bits of the Q16.16 coordinates.
    localparam int FRAC_BITS = 16;

    // Field widths of a node record and of a node reference.
    localparam int LINK_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int NODE_REF_W = LINK_W + 1;
    localparam int INFO_W     = LINK_W + COUNT_W + 2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    // Split axis codes; the spare code is taken as z.
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;
    localparam logic [1:0] AXIS_SPARE = 2'd3;

    // One command word: a node write or a ray to trace.
    typedef struct packed {
        logic               command;
        logic [6:0]         node_index;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] link_or_tmin;
        logic signed [31:0] count_or_tmax;
        logic [1:0]         split_axis;
    } cmd_word_t;

    // One result word.
    typedef struct packed {
        logic [LINK_W-1:0]  prim_offset;
        logic [COUNT_W-1:0] leaf_count;
        logic               last;
        logic               error;
    } res_word_t;

    // The spare axis code is taken as z.
    function automatic logic [1:0] clamp_axis(input logic [1:0] axis);
        logic [1:0] res;
        res = (axis == AXIS_SPARE) ? AXIS_Z : axis;
        return res;
    endfunction

endpackage

FILE: sv/bvh_rt_stream_if.sv
// ----------------------------------------------------------------------------
// bvh_rt_stream_if
// Valid/ready channel that carries one word of a given type.
// ----------------------------------------------------------------------------
interface bvh_rt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bvh_rt_slab_unit.sv
// ----------------------------------------------------------------------------
// bvh_rt_slab_unit
// Shared slab unit: t = sat(floor(sat(bound - origin) * inv / 2^16)).
// The product is built from four half-width partial products over cycles.
// ----------------------------------------------------------------------------
module bvh_rt_slab_unit #(
    parameter int COORD_WIDTH = bvh_rt_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] bound,
    input  logic signed [COORD_WIDTH-1:0] origin,
    input  logic signed [COORD_WIDTH-1:0] inv,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] t_out
);
    localparam int CW    = COORD_WIDTH;
    localparam int HW    = (CW + 1) / 2;
    localparam int ACC_W = 2 * CW;
    localparam int SH_W  = $clog2(2 * HW + 1);
    localparam logic [ACC_W-1:0] LIM = ACC_W'(1) << (CW - 1);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [2:0] {U_IDLE, U_ABS, U_MUL, U_RND, U_SAT} ustate_t;

    ustate_t             state_reg;
    logic [CW-1:0]       d_reg;
    logic [CW-1:0]       inv_reg;
    logic [CW-1:0]       ma_reg;
    logic [CW-1:0]       mb_reg;
    logic                neg_reg;
    logic [2:0]          k_reg;
    logic [2*HW-1:0]     pp_reg;
    logic [SH_W-1:0]     sh_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    mag_reg;
    logic [CW-1:0]       t_reg;
    logic                done_reg;

    logic signed [CW:0]  diff;
    logic [CW-1:0]       d_sat;
    logic [HW-1:0]       a_lo, a_hi, b_lo, b_hi;
    logic [HW-1:0]       pa, pb;
    logic [SH_W-1:0]     sh;
    logic [ACC_W-1:0]    q;
    logic                rem;

    // Difference of bound and origin, saturated to the coordinate range.
    always_comb
    begin
        diff = {bound[CW-1], bound} - {origin[CW-1], origin};
        if (diff[CW] != diff[CW-1])
        begin
            d_sat = diff[CW] ? C_MIN : C_MAX;
        end
        else
        begin
            d_sat = diff[CW-1:0];
        end
    end

    // Operand halves for the partial product of this step.
    always_comb
    begin
        a_lo = ma_reg[HW-1:0];
        a_hi = HW'(ma_reg >> HW);
        b_lo = mb_reg[HW-1:0];
        b_hi = HW'(mb_reg >> HW);
        unique case (k_reg[1:0])
            2'd0:
            begin
                pa = a_lo;
                pb = b_lo;
                sh = '0;
            end
            2'd1:
            begin
                pa = a_lo;
                pb = b_hi;
                sh = SH_W'(HW);
            end
            2'd2:
            begin
                pa = a_hi;
                pb = b_lo;
                sh = SH_W'(HW);
            end
            default:
            begin
                pa = a_hi;
                pb = b_hi;
                sh = SH_W'(2 * HW);
            end
        endcase
        q   = acc_reg >> bvh_rt_pkg::FRAC_BITS;
        rem = |acc_reg[bvh_rt_pkg::FRAC_BITS-1:0];
    end

    // Sequencer of the unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        d_reg     <= d_sat;
                        inv_reg   <= inv;
                        state_reg <= U_ABS;
                    end
                end
                U_ABS:
                begin
                    ma_reg    <= d_reg[CW-1] ? CW'(-d_reg) : d_reg;
                    mb_reg    <= inv_reg[CW-1] ? CW'(-inv_reg) : inv_reg;
                    neg_reg   <= d_reg[CW-1] ^ inv_reg[CW-1];
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= U_MUL;
                end
                U_MUL:
                begin
                    if (k_reg != 3'd4)
                    begin
                        pp_reg <= pa * pb;
                        sh_reg <= sh;
                    end
                    if (k_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + (ACC_W'(pp_reg) << sh_reg);
                    end
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd4)
                    begin
                        state_reg <= U_RND;
                    end
                end
                U_RND:
                begin
                    mag_reg   <= neg_reg ? (q + ACC_W'(rem)) : q;
                    state_reg <= U_SAT;
                end
                U_SAT:
                begin
                    if (neg_reg)
                    begin
                        t_reg <= (mag_reg > LIM) ? C_MIN : CW'(ACC_W'(0) - mag_reg);
                    end
                    else
                    begin
                        t_reg <= (mag_reg > (LIM - ACC_W'(1))) ? C_MAX : CW'(mag_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign t_out = $signed(t_reg);

endmodule

FILE: sv/bvh_rt_walker.sv
// ----------------------------------------------------------------------------
// bvh_rt_walker
// Node store, node stack and the walk sequencer that drives the slab unit.
// ----------------------------------------------------------------------------
module bvh_rt_walker #(
    parameter int NODE_COUNT  = bvh_rt_pkg::DEF_NODE_COUNT,
    parameter int STACK_DEPTH = bvh_rt_pkg::DEF_STACK_DEPTH,
    parameter int COORD_WIDTH = bvh_rt_pkg::DEF_COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  bvh_rt_pkg::cmd_word_t cmd_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bvh_rt_pkg::res_word_t res_word
);
    localparam int CW          = COORD_WIDTH;
    localparam int AW          = $clog2(NODE_COUNT);
    localparam int SW          = $clog2(STACK_DEPTH);
    localparam int TW          = SW + 1;
    localparam int VW          = $clog2(2 * NODE_COUNT);
    localparam int VISIT_LIMIT = 2 * NODE_COUNT - 1;
    localparam int RW          = $clog2(bvh_rt_pkg::MAX_RESULTS + 1);
    localparam int NRW         = bvh_rt_pkg::NODE_REF_W;
    localparam logic signed [48:0] C_HI = (49'sd1 <<< (CW - 1)) - 49'sd1;
    localparam logic signed [48:0] C_LO = -C_HI - 49'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_VISIT, S_SLAB, S_WAIT, S_DECIDE, S_EMIT, S_POP, S_POPW, S_FINISH
    } wstate_t;

    // Input coordinate saturated to the working width.
    function automatic logic [CW-1:0] coord_in(input logic [31:0] x);
        logic signed [48:0] w;
        logic [CW-1:0]      res;
        w = 49'($signed(x));
        if (w > C_HI)
        begin
            res = C_HI[CW-1:0];
        end
        else if (w < C_LO)
        begin
            res = C_LO[CW-1:0];
        end
        else
        begin
            res = w[CW-1:0];
        end
        return res;
    endfunction

    // Node store and stack.
    logic [5:0][CW-1:0]              bnd_mem [NODE_COUNT];
    logic [bvh_rt_pkg::INFO_W-1:0]   info_mem [NODE_COUNT];
    logic [NRW-1:0]                  stack_mem [STACK_DEPTH];
    logic [5:0][CW-1:0]              bnd_rd_reg;
    logic [bvh_rt_pkg::INFO_W-1:0]   info_rd_reg;
    logic [NRW-1:0]                  stack_rd_reg;

    wstate_t              state_reg;
    logic [2:0][CW-1:0]   org_reg;
    logic [2:0][CW-1:0]   inv_reg;
    logic [CW-1:0]        ray_tmin_reg;
    logic [CW-1:0]        ray_tmax_reg;
    logic [NRW-1:0]       node_reg;
    logic [TW-1:0]        top_reg;
    logic [VW-1:0]        visit_reg;
    logic [RW-1:0]        nres_reg;
    logic                 err_reg;
    logic                 held_valid_reg;
    logic [bvh_rt_pkg::LINK_W-1:0]  held_off_reg;
    logic [bvh_rt_pkg::COUNT_W-1:0] held_cnt_reg;
    logic [2:0]           job_reg;
    logic                 miss_reg;
    logic signed [CW-1:0] tmin_reg;
    logic signed [CW-1:0] tmax_reg;
    logic signed [CW-1:0] lo_reg;

    logic                 node_wr;
    logic [AW-1:0]        node_wr_addr;
    logic                 push;
    logic [NRW-1:0]       push_val;
    logic [NRW-1:0]       near_node;
    logic                 pop_rd;
    logic                 node_ok;
    logic                 hit;
    logic [bvh_rt_pkg::LINK_W-1:0]  link;
    logic [bvh_rt_pkg::COUNT_W-1:0] cnt;
    logic [1:0]           dec_axis;
    logic                 dir_neg;
    logic [NRW-1:0]       link_ext;
    logic [1:0]           job_axis;
    logic                 sel_max;
    logic signed [CW-1:0] slab_bound;
    logic                 slab_start;
    logic                 slab_done;
    logic signed [CW-1:0] slab_t;
    logic                 stack_full;
    logic                 res_full;
    logic                 split_final;

    // Decode of the node record and of the current slab job.
    always_comb
    begin
        node_wr      = (state_reg == S_IDLE) && cmd_valid
                       && (cmd_word.command == bvh_rt_pkg::CMD_WRITE)
                       && (32'(cmd_word.node_index) < NODE_COUNT);
        node_wr_addr = AW'(cmd_word.node_index);
        node_ok      = node_reg < NRW'(NODE_COUNT);
        link         = info_rd_reg[bvh_rt_pkg::LINK_W-1:0];
        cnt          = info_rd_reg[bvh_rt_pkg::LINK_W +: bvh_rt_pkg::COUNT_W];
        dec_axis     = bvh_rt_pkg::clamp_axis(info_rd_reg[bvh_rt_pkg::INFO_W-1 -: 2]);
        dir_neg      = inv_reg[dec_axis][CW-1];
        link_ext     = NRW'(link);
        near_node    = dir_neg ? (link_ext + NRW'(1)) : link_ext;
        push_val     = dir_neg ? link_ext : (link_ext + NRW'(1));
        hit          = !miss_reg && (tmin_reg < $signed(ray_tmax_reg))
                       && (tmax_reg > $signed(ray_tmin_reg));
        stack_full   = top_reg >= TW'(STACK_DEPTH);
        res_full     = nres_reg >= RW'(bvh_rt_pkg::MAX_RESULTS);
        push         = (state_reg == S_DECIDE) && hit && (cnt == '0) && !stack_full;
        pop_rd       = (state_reg == S_POP) && (top_reg != '0);
        job_axis     = job_reg[2:1];
        sel_max      = inv_reg[job_axis][CW-1] != job_reg[0];
        slab_bound   = $signed(bnd_rd_reg[sel_max ? (3'd3 + 3'(job_axis)) : 3'(job_axis)]);
        slab_start   = state_reg == S_SLAB;
        split_final  = held_valid_reg && err_reg && !res_full;
    end

    // Node store: written by write commands, read once per visit.
    always_ff @(posedge clk)
    begin
        if (node_wr)
        begin
            bnd_mem[node_wr_addr]  <= {coord_in(cmd_word.b_z), coord_in(cmd_word.b_y),
                                       coord_in(cmd_word.b_x), coord_in(cmd_word.a_z),
                                       coord_in(cmd_word.a_y), coord_in(cmd_word.a_x)};
            info_mem[node_wr_addr] <= {cmd_word.split_axis, cmd_word.count_or_tmax[7:0],
                                       cmd_word.link_or_tmin[15:0]};
        end
        if (state_reg == S_VISIT)
        begin
            bnd_rd_reg  <= bnd_mem[node_reg[AW-1:0]];
            info_rd_reg <= info_mem[node_reg[AW-1:0]];
        end
    end

    // Node stack: far children wait here.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[top_reg[SW-1:0]] <= push_val;
        end
        if (pop_rd)
        begin
            stack_rd_reg <= stack_mem[SW'(top_reg - TW'(1))];
        end
    end

    // Shared slab arithmetic.
    bvh_rt_slab_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_slab (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (slab_start),
        .bound  (slab_bound),
        .origin ($signed(org_reg[job_axis])),
        .inv    ($signed(inv_reg[job_axis])),
        .done   (slab_done),
        .t_out  (slab_t)
    );

    // Walk sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_reg       <= '0;
            top_reg        <= '0;
            visit_reg      <= '0;
            nres_reg       <= '0;
            err_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            job_reg        <= '0;
            miss_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && (cmd_word.command == bvh_rt_pkg::CMD_TRACE))
                    begin
                        org_reg        <= {coord_in(cmd_word.a_z), coord_in(cmd_word.a_y),
                                           coord_in(cmd_word.a_x)};
                        inv_reg        <= {coord_in(cmd_word.b_z), coord_in(cmd_word.b_y),
                                           coord_in(cmd_word.b_x)};
                        ray_tmin_reg   <= coord_in(cmd_word.link_or_tmin);
                        ray_tmax_reg   <= coord_in(cmd_word.count_or_tmax);
                        node_reg       <= '0;
                        top_reg        <= '0;
                        visit_reg      <= '0;
                        nres_reg       <= '0;
                        err_reg        <= 1'b0;
                        held_valid_reg <= 1'b0;
                        state_reg      <= S_VISIT;
                    end
                end
                S_VISIT:
                begin
                    if (visit_reg >= VW'(VISIT_LIMIT))
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        visit_reg <= visit_reg + VW'(1);
                        job_reg   <= '0;
                        miss_reg  <= 1'b0;
                        state_reg <= node_ok ? S_SLAB : S_POP;
                    end
                end
                S_SLAB:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (slab_done)
                    begin
                        // Fold the slab intervals axis by axis.
                        unique case (job_reg)
                            3'd0:
                            begin
                                tmin_reg <= slab_t;
                            end
                            3'd1:
                            begin
                                tmax_reg <= slab_t;
                            end
                            3'd3, 3'd5:
                            begin
                                if ((tmin_reg > slab_t) || (lo_reg > tmax_reg))
                                begin
                                    miss_reg <= 1'b1;
                                end
                                if (lo_reg > tmin_reg)
                                begin
                                    tmin_reg <= lo_reg;
                                end
                                if (slab_t < tmax_reg)
                                begin
                                    tmax_reg <= slab_t;
                                end
                            end
                            default:
                            begin
                                lo_reg <= slab_t;
                            end
                        endcase
                        job_reg   <= job_reg + 3'd1;
                        state_reg <= (job_reg == 3'd5) ? S_DECIDE : S_SLAB;
                    end
                end
                S_DECIDE:
                begin
                    if (!hit)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (cnt == '0)
                    begin
                        if (stack_full)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            top_reg   <= top_reg + TW'(1);
                            node_reg  <= near_node;
                            state_reg <= S_VISIT;
                        end
                    end
                    else if (res_full)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        nres_reg <= nres_reg + RW'(1);
                        if (held_valid_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            held_valid_reg <= 1'b1;
                            held_off_reg   <= link;
                            held_cnt_reg   <= cnt;
                            state_reg      <= S_POP;
                        end
                    end
                end
                S_EMIT:
                begin
                    // The held leaf goes out; the new leaf takes its place.
                    if (res_ready)
                    begin
                        held_off_reg <= link;
                        held_cnt_reg <= cnt;
                        state_reg    <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (top_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        top_reg   <= top_reg - TW'(1);
                        state_reg <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    node_reg  <= stack_rd_reg;
                    state_reg <= S_VISIT;
                end
                S_FINISH:
                begin
                    if (res_ready)
                    begin
                        if (split_final)
                        begin
                            held_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result word toward the output register.
    always_comb
    begin
        cmd_ready = state_reg == S_IDLE;
        res_valid = (state_reg == S_EMIT) || (state_reg == S_FINISH);
        if ((state_reg == S_EMIT) || split_final)
        begin
            res_word.prim_offset = held_off_reg;
            res_word.leaf_count  = held_cnt_reg;
            res_word.last        = 1'b0;
            res_word.error       = 1'b0;
        end
        else
        begin
            res_word.prim_offset = held_valid_reg ? held_off_reg : '0;
            res_word.leaf_count  = held_valid_reg ? held_cnt_reg : '0;
            res_word.last        = 1'b1;
            res_word.error       = err_reg;
        end
    end

endmodule

FILE: sv/bvh_ray_traversal.sv
// ----------------------------------------------------------------------------
// bvh_ray_traversal
// Ray walk over a flattened bounding-volume tree with a slab box test.
// ----------------------------------------------------------------------------
// Use of the block:
// The cmd channel takes one word at a time. A write word (command 0) loads
// one tree node; cmd ready stays high after it.
// A trace word (command 1) starts a walk from node 0; cmd ready stays low
// until the last result word of that ray has entered the output register.
// Six slab values go one after another through the shared subtract,
// four-step multiply and round unit, each one done before the next starts.
// A leaf that sends a word also waits out any receiver stall; a child
// outside the tree skips the slab test and goes straight to a pop.
// The res channel gives one word per hit leaf; the final word has last set,
// and an empty word (count 0) stands alone when no leaf was hit.
// The result leaves through an output register: when the receiver stalls,
// the walk pauses at its next result until the register drains.
// Reset clears the control state; the node store is undefined until written.
// ----------------------------------------------------------------------------
module bvh_ray_traversal #(
    parameter int NODE_COUNT  = bvh_rt_pkg::DEF_NODE_COUNT,
    parameter int STACK_DEPTH = bvh_rt_pkg::DEF_STACK_DEPTH,
    parameter int COORD_WIDTH = bvh_rt_pkg::DEF_COORD_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    bvh_rt_stream_if.sink   cmd,
    bvh_rt_stream_if.source result
);
    logic                  w_res_valid;
    logic                  w_res_ready;
    bvh_rt_pkg::res_word_t w_res_word;
    logic                  out_valid_reg;
    bvh_rt_pkg::res_word_t out_word_reg;

    // Walk sequencer with node store and stack.
    bvh_rt_walker #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_DEPTH (STACK_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_word  (cmd.data),
        .res_valid (w_res_valid),
        .res_ready (w_res_ready),
        .res_word  (w_res_word)
    );

    // Output register: refilled when empty or when its word is taken.
    assign w_res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (w_res_ready)
        begin
            out_valid_reg <= w_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_res_ready && w_res_valid)
        begin
            out_word_reg <= w_res_word;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

endmodule

FILE: sv/bvh_rt_checker.sv
// ----------------------------------------------------------------------------
// bvh_rt_checker
// Port-level checks of the tree walker, bound to its top level.
// ----------------------------------------------------------------------------
`include "bvh_ray_traversal_assert.svh"

module bvh_rt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        cmd_command,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_offset,
    input logic [7:0]  res_count,
    input logic        res_last,
    input logic        res_error
);
    logic cmd_take;

    assign cmd_take = cmd_valid && cmd_ready;

    // A stalled result word holds its contents.
    `BVH_RT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_offset) && $stable(res_count) && $stable(res_last) && $stable(res_error), "result word changed while stalled")

    // A traced ray keeps the block busy.
    `BVH_RT_ASSERT_NEXT(a_trace_busy, cmd_take && (cmd_command == bvh_rt_pkg::CMD_TRACE), !cmd_ready, "ready after a trace word")

    // A node write leaves the block ready for the next word.
    `BVH_RT_ASSERT_NEXT(a_write_ready, cmd_take && (cmd_command == bvh_rt_pkg::CMD_WRITE), cmd_ready, "busy after a write word")

    // An empty word only closes a ray.
    `BVH_RT_ASSERT_NOW(a_empty_last, res_valid && (res_count == 8'd0), res_last, "empty word not last")

    // An abort is flagged on the final word only.
    `BVH_RT_ASSERT_NOW(a_error_last, res_valid && res_error, res_last, "error on a word that is not last")

endmodule

bind bvh_ray_traversal bvh_rt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_command (cmd.data.command),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_offset  (result.data.prim_offset),
    .res_count   (result.data.leaf_count),
    .res_last    (result.data.last),
    .res_error   (result.data.error)
);
